// ----- hdl/tcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the trilinear charge deposit block.
// No dependencies; every file but tcd_ram imports this package.
package tcd_pkg;

   // Node address width: the farthest node of a deposit is below 3 * 4096
   localparam int NODE_W = 14;
   // Trilinear weight intermediate and multiplier product widths
   localparam int A_W    = 45;
   localparam int PROD_W = 62;

   // Queue between the front and the back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // Request function codes
   localparam logic [1:0] FN_DEPOSIT = 2'd0;
   localparam logic [1:0] FN_READ    = 2'd1;
   localparam logic [1:0] FN_WRITE   = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_CHARGE_SCALE = 2'd0;
   localparam logic [1:0] CSR_STRIDE_Y     = 2'd1;
   localparam logic [1:0] CSR_STRIDE_Z     = 2'd2;

   // Operations carried by a queue word
   localparam logic [1:0] WOP_NOP   = 2'd0;
   localparam logic [1:0] WOP_READ  = 2'd1;
   localparam logic [1:0] WOP_WRITE = 2'd2;
   localparam logic [1:0] WOP_ADD   = 2'd3;

   // One node operation handed from the front to the back
   typedef struct packed {
      logic [1:0]        op;
      logic [NODE_W-1:0] node;
      logic [31:0]       value;   // weight for an add, data for a write
      logic              wsat;    // weight was clipped to 32 bits
      logic [1:0]        status;  // status of a no-op word
      logic              last;    // closes the item, a response follows
      logic              batch;
   } word_type;

   typedef struct packed {
      logic [31:0] charge_scale;
      logic [11:0] stride_y;
      logic [11:0] stride_z;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- hdl/trilinear_charge_deposit.sv -----
`timescale 1ns / 1ps
// Deposit: 15 products on the front's multipliers, each a multiply state then a rounding
// state; the front then pushes eight node words into the four-entry queue as it has room
// and returns to idle, while the back spends a fetch state and a data state per node.
// Read, write and no-op words: one queue word each; reads also pass the back's data state.
// Reset: registers take their reset values, then the store is zeroed one node per
// cycle up to the last node, with req_stall high; csr writes are taken throughout.
module trilinear_charge_deposit #(
   parameter int GRID_NODES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_offset_x,
   input  logic signed [15:0] req_offset_y,
   input  logic signed [15:0] req_offset_z,
   input  logic [11:0]        req_cell_index,
   input  logic [23:0]        req_particle_weight,
   input  logic signed [31:0] req_write_value,
   input  logic               req_end_of_batch,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_node_value,
   output logic               rsp_batch_done,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import tcd_pkg::*;

   cfg_type    cfg_ff;
   logic       clearing;
   qstat_type  qstat;
   logic       push, pop;
   word_type   push_word, head_word;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charge_scale <= '0;
         cfg_ff.stride_y     <= 12'd16;
         cfg_ff.stride_z     <= 12'd256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHARGE_SCALE: cfg_ff.charge_scale <= csr_wdata;
            CSR_STRIDE_Y:     cfg_ff.stride_y     <= csr_wdata[11:0];
            CSR_STRIDE_Z:     cfg_ff.stride_z     <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   tcd_front #(
      .GRID_NODES (GRID_NODES)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_offset_x        (req_offset_x),
      .req_offset_y        (req_offset_y),
      .req_offset_z        (req_offset_z),
      .req_cell_index      (req_cell_index),
      .req_particle_weight (req_particle_weight),
      .req_write_value     (req_write_value),
      .req_end_of_batch    (req_end_of_batch),
      .cfg                 (cfg_ff),
      .clearing            (clearing),
      .qstat               (qstat),
      .push                (push),
      .push_word           (push_word)
   );

   tcd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .qstat     (qstat)
   );

   tcd_back #(
      .GRID_NODES (GRID_NODES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .head_word      (head_word),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_node_value (rsp_node_value),
      .rsp_batch_done (rsp_batch_done)
   );

endmodule

// ----- hdl/tcd_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module tcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/tcd_fifo.sv -----
`timescale 1ns / 1ps
// Short word queue between the deposit front and the memory back.
// Depends on tcd_pkg.
module tcd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcd_pkg::word_type push_word,
   input  logic              pop,
   output tcd_pkg::word_type head_word,
   output tcd_pkg::qstat_type qstat
);
   import tcd_pkg::*;

   word_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_word   = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- hdl/tcd_front.sv -----
`timescale 1ns / 1ps
// Request front: accepts words, checks ranges, builds the eight trilinear
// weights with two multipliers and queues node operations. Uses tcd_pkg.
module tcd_front #(
   parameter int GRID_NODES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_offset_x,
   input  logic signed [15:0] req_offset_y,
   input  logic signed [15:0] req_offset_z,
   input  logic [11:0]        req_cell_index,
   input  logic [23:0]        req_particle_weight,
   input  logic signed [31:0] req_write_value,
   input  logic               req_end_of_batch,
   input  tcd_pkg::cfg_type   cfg,
   input  logic               clearing,
   input  tcd_pkg::qstat_type qstat,
   output logic               push,
   output tcd_pkg::word_type  push_word
);
   import tcd_pkg::*;

   localparam logic [31:0] GRID_LIM = 32'(GRID_NODES);

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_QWMUL = 3'd1;
   localparam logic [2:0] F_QWRND = 3'd2;
   localparam logic [2:0] F_MUL   = 3'd3;
   localparam logic [2:0] F_RND   = 3'd4;
   localparam logic [2:0] F_EMIT  = 3'd5;

   localparam logic signed [16:0] F_ONE = 17'sd16384;

   logic [2:0]               state_ff, state_in;
   logic [1:0]               func_ff;
   logic signed [15:0]       dx_ff, dy_ff, dz_ff;
   logic [11:0]              idx_ff;
   logic [23:0]              weight_ff;
   logic [31:0]              wval_ff;
   logic                     batch_ff;
   logic                     oor_ff, oor_in;
   logic [1:0]               stage_ff, stage_in;
   logic [1:0]               k_ff, k_in;
   logic                     hi_ff, hi_in;
   logic [2:0]               e_ff, e_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [A_W-1:0]    a_ff [8];

   logic                     accept;
   logic [NODE_W-1:0]        far_node;
   logic [2:0]               rd_idx;
   logic signed [A_W-1:0]    a_rd;
   logic signed [15:0]       d_sel;
   logic signed [16:0]       f_val;
   logic signed [PROD_W-1:0] qw_prod, stage_prod;
   logic signed [PROD_W-1:0] rbias, rsum, rshift;
   logic signed [A_W-1:0]    rnd;
   logic [2:0]               n_step, dst;
   logic                     a_we;
   logic [2:0]               a_widx;
   logic                     fits32;
   logic [31:0]              w_sat;
   logic                     deposit;

   assign req_stall = (state_ff != F_IDLE) || clearing;
   assign accept    = req_valid && !req_stall;

   // range check on the incoming word
   assign far_node = NODE_W'(req_cell_index) + NODE_W'(req_stall ? 12'd0 : cfg.stride_y)
                   + NODE_W'(cfg.stride_z) + NODE_W'(1);
   always_comb begin
      case (req_func)
         FN_DEPOSIT: oor_in = (32'(far_node) >= GRID_LIM);
         FN_READ,
         FN_WRITE:   oor_in = (32'(req_cell_index) >= GRID_LIM);
         default:    oor_in = 1'b0;
      endcase
   end

   // weight array read port, shared by the multiplier and the emitter
   assign rd_idx = (state_ff == F_EMIT) ? e_ff : {1'b0, k_ff};
   assign a_rd   = a_ff[rd_idx];

   // factor (1 -/+ d) of the current axis
   always_comb begin
      case (stage_ff)
         2'd0:    d_sel = dx_ff;
         2'd1:    d_sel = dy_ff;
         default: d_sel = dz_ff;
      endcase
   end
   assign f_val = hi_ff ? F_ONE + 17'(d_sel) : F_ONE - 17'(d_sel);

   // multipliers: the weight times the scale once, then the axis products
   assign qw_prod    = PROD_W'(signed'({1'b0, weight_ff})) * PROD_W'(signed'(cfg.charge_scale));
   assign stage_prod = PROD_W'(a_rd) * PROD_W'(f_val);

   // round half away from zero: add half, minus one when negative, then shift
   always_comb begin
      rbias  = (state_ff == F_QWRND) ? PROD_W'(32'sd32768) : PROD_W'(32'sd8192);
      rsum   = prod_ff + rbias - PROD_W'(signed'({1'b0, prod_ff[PROD_W-1]}));
      rshift = (state_ff == F_QWRND) ? (rsum >>> 16) : (rsum >>> 14);
      rnd    = rshift[A_W-1:0];
   end

   assign n_step = 3'd1 << stage_ff;
   assign dst    = hi_ff ? {1'b0, k_ff} + n_step : {1'b0, k_ff};

   // clip the emitted weight to 32 bits
   assign fits32 = (&a_rd[A_W-1:31]) || !(|a_rd[A_W-1:31]);
   assign w_sat  = fits32 ? a_rd[31:0] : (a_rd[A_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);

   assign deposit = (func_ff == FN_DEPOSIT) && !oor_ff;

   // emitted word
   always_comb begin
      push_word = '0;
      push_word.batch = batch_ff;
      if (deposit) begin
         push_word.op    = WOP_ADD;
         push_word.node  = NODE_W'(idx_ff) + NODE_W'(e_ff[0])
                         + (e_ff[1] ? NODE_W'(cfg.stride_y) : NODE_W'(0))
                         + (e_ff[2] ? NODE_W'(cfg.stride_z) : NODE_W'(0));
         push_word.value = w_sat;
         push_word.wsat  = !fits32;
         push_word.last  = (e_ff == 3'd7);
      end else begin
         push_word.node  = NODE_W'(idx_ff);
         push_word.value = wval_ff;
         push_word.last  = 1'b1;
         if (oor_ff) begin
            push_word.op     = WOP_NOP;
            push_word.status = ST_RANGE;
         end else begin
            case (func_ff)
               FN_READ:  push_word.op = WOP_READ;
               FN_WRITE: push_word.op = WOP_WRITE;
               default:  push_word.op = WOP_NOP;
            endcase
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      k_in     = k_ff;
      hi_in    = hi_ff;
      e_in     = e_ff;
      prod_in  = prod_ff;
      a_we     = 1'b0;
      a_widx   = dst;
      push     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            e_in = '0;
            if (accept) begin
               state_in = (req_func == FN_DEPOSIT && !oor_in) ? F_QWMUL : F_EMIT;
            end
         end
         F_QWMUL: begin
            prod_in  = qw_prod;
            state_in = F_QWRND;
         end
         F_QWRND: begin
            a_we     = 1'b1;
            a_widx   = 3'd0;
            stage_in = 2'd0;
            k_in     = 2'd0;
            hi_in    = 1'b1;
            state_in = F_MUL;
         end
         F_MUL: begin
            prod_in  = stage_prod;
            state_in = F_RND;
         end
         F_RND: begin
            a_we     = 1'b1;
            state_in = F_MUL;
            if (hi_ff) begin
               hi_in = 1'b0;
            end else if (k_ff == 2'd0) begin
               if (stage_ff == 2'd2) begin
                  state_in = F_EMIT;
               end else begin
                  stage_in = stage_ff + 1'b1;
                  k_in     = (stage_ff == 2'd0) ? 2'd1 : 2'd3;
                  hi_in    = 1'b1;
               end
            end else begin
               k_in  = k_ff - 1'b1;
               hi_in = 1'b1;
            end
         end
         F_EMIT: begin
            if (!qstat.full) begin
               push = 1'b1;
               e_in = e_ff + 1'b1;
               if (push_word.last) begin
                  state_in = F_IDLE;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // item and sequencing registers
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      k_ff     <= k_in;
      hi_ff    <= hi_in;
      e_ff     <= e_in;
      prod_ff  <= prod_in;
      if (accept) begin
         func_ff   <= req_func;
         dx_ff     <= req_offset_x;
         dy_ff     <= req_offset_y;
         dz_ff     <= req_offset_z;
         idx_ff    <= req_cell_index;
         weight_ff <= req_particle_weight;
         wval_ff   <= req_write_value;
         batch_ff  <= req_end_of_batch;
         oor_ff    <= oor_in;
      end
      if (a_we) begin
         a_ff[a_widx] <= rnd;
      end
   end

endmodule

// ----- hdl/tcd_back.sv -----
`timescale 1ns / 1ps
// Memory back: clears the charge store after reset, then runs queued node words, adds
// as read-modify-write, and drives the response register. Uses tcd_pkg, tcd_ram.
module tcd_back #(
   parameter int GRID_NODES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  tcd_pkg::qstat_type qstat,
   input  tcd_pkg::word_type  head_word,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_node_value,
   output logic               rsp_batch_done
);
   import tcd_pkg::*;

   localparam int ADDR_W = $clog2(GRID_NODES);
   localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(GRID_NODES - 1);

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_FETCH = 2'd1;
   localparam logic [1:0] B_DATA  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   word_type          cur_ff, cur_in;
   logic              sat_acc_ff, sat_acc_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [31:0]       rsp_value_ff;
   logic              rsp_batch_ff;

   logic                        out_free;
   logic [ADDR_W+NODE_W-1:0]    head_wide, cur_wide;
   logic [ADDR_W-1:0]           head_addr, cur_addr;
   logic                        ram_en, ram_we;
   logic [ADDR_W-1:0]           ram_addr;
   logic [31:0]                 ram_wdata, ram_rdata;
   logic signed [32:0]          sum;
   logic                        add_sat;
   logic [31:0]                 sum_sat;
   logic                        step_sat;
   logic                        emit;
   logic [1:0]                  emit_status;
   logic [31:0]                 emit_value;
   logic                        emit_batch;

   assign clearing = (state_ff == B_CLEAR);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // node number to memory address; in-range nodes fit the address
   assign head_wide = {{ADDR_W{1'b0}}, head_word.node};
   assign cur_wide  = {{ADDR_W{1'b0}}, cur_ff.node};
   assign head_addr = head_wide[ADDR_W-1:0];
   assign cur_addr  = cur_wide[ADDR_W-1:0];

   // saturating node update
   assign sum      = 33'(signed'(ram_rdata)) + 33'(signed'(cur_ff.value));
   assign add_sat  = (sum[32] != sum[31]);
   assign sum_sat  = add_sat ? (sum[32] ? 32'h8000_0000 : 32'h7fff_ffff) : sum[31:0];
   assign step_sat = add_sat || cur_ff.wsat;

   tcd_ram #(
      .WIDTH (32),
      .DEPTH (GRID_NODES)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cur_in      = cur_ff;
      sat_acc_in  = sat_acc_ff;
      pop         = 1'b0;
      ram_en      = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = head_addr;
      ram_wdata   = '0;
      emit        = 1'b0;
      emit_status = ST_OK;
      emit_value  = '0;
      emit_batch  = head_word.batch;
      case (state_ff)
         // zero one node per cycle
         B_CLEAR: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LAST_NODE) begin
               state_in = B_FETCH;
            end
         end
         B_FETCH: begin
            if (!qstat.empty) begin
               case (head_word.op)
                  WOP_NOP: begin
                     if (out_free) begin
                        pop         = 1'b1;
                        emit        = 1'b1;
                        emit_status = head_word.status;
                     end
                  end
                  WOP_WRITE: begin
                     if (out_free) begin
                        pop       = 1'b1;
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata = head_word.value;
                        emit      = 1'b1;
                     end
                  end
                  default: begin
                     pop      = 1'b1;
                     ram_en   = 1'b1;
                     cur_in   = head_word;
                     state_in = B_DATA;
                  end
               endcase
            end
         end
         B_DATA: begin
            emit_batch = cur_ff.batch;
            ram_addr   = cur_addr;
            if (cur_ff.op == WOP_READ) begin
               if (out_free) begin
                  emit       = 1'b1;
                  emit_value = ram_rdata;
                  state_in   = B_FETCH;
               end
            end else if (!cur_ff.last || out_free) begin
               ram_en    = 1'b1;
               ram_we    = 1'b1;
               ram_wdata = sum_sat;
               state_in  = B_FETCH;
               if (cur_ff.last) begin
                  emit        = 1'b1;
                  emit_status = (sat_acc_ff || step_sat) ? ST_SAT : ST_OK;
                  sat_acc_in  = 1'b0;
               end else begin
                  sat_acc_in = sat_acc_ff || step_sat;
               end
            end
         end
         default: state_in = B_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         sat_acc_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         sat_acc_ff <= sat_acc_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload and current word
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_value_ff  <= emit_value;
         rsp_batch_ff  <= emit_batch;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_node_value = rsp_value_ff;
   assign rsp_batch_done = rsp_batch_ff;

endmodule

// ----- hdl/tcd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for trilinear_charge_deposit, attached by bind.
// Depends on tcd_pkg.
module tcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_node_value,
   input logic        rsp_batch_done
);
   import tcd_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_node_value) && $stable(rsp_batch_done))
      else $error("response word changed while stalled");

   // the store clear starts right after reset, with no response pending
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("requests taken or response shown during store clear");

   // only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE
         || rsp_status == ST_SAT))
      else $error("undefined status code");

   // a node value only comes with a good read
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_node_value == 32'd0)
      else $error("node value on a failed or saturated word");

endmodule

bind trilinear_charge_deposit tcd_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_node_value (rsp_node_value),
   .rsp_batch_done (rsp_batch_done)
);

// ----- tb/trilinear_charge_deposit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for trilinear_charge_deposit: a local charge-store model
// predicts every response word, which is compared field by field as it arrives.
// Depends on tcd_pkg for the function, status and register codes.
module trilinear_charge_deposit_tb;
   import tcd_pkg::*;

   localparam int GRID_NODES   = 4096;
   localparam int LIMIT_CYCLES = 400_000;
   localparam int MAX_REPORTS  = 200;
   // Function code outside the defined set, handled as a no-op
   localparam logic [1:0] FN_UNUSED = 2'd3;
   localparam longint SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SAT_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef struct {
      logic [1:0]         func;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic signed [15:0] offset_z;
      logic [11:0]        cell_index;
      logic [23:0]        weight;
      logic signed [31:0] write_value;
      logic               eob;
   } request_type;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] node_value;
      logic               batch_done;
   } response_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FN_DEPOSIT;
   logic signed [15:0] req_offset_x = '0;
   logic signed [15:0] req_offset_y = '0;
   logic signed [15:0] req_offset_z = '0;
   logic [11:0]        req_cell_index = '0;
   logic [23:0]        req_particle_weight = '0;
   logic signed [31:0] req_write_value = '0;
   logic               req_end_of_batch = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_node_value;
   logic               rsp_batch_done;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_CHARGE_SCALE;
   logic [31:0]        csr_wdata = '0;

   // Model state: node store and register copies
   logic signed [31:0] charge_model [GRID_NODES];
   logic signed [31:0] scale_cfg = '0;
   logic [11:0]        stride_y_cfg = 12'd16;
   logic [11:0]        stride_z_cfg = 12'd256;

   response_type expected_responses [$];
   int  error_count = 0;
   int  idle_pct = 37;
   int  recent_base = 0;
   bit  req_live = 1'b0;

   trilinear_charge_deposit #(.GRID_NODES(GRID_NODES)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_offset_x        (req_offset_x),
      .req_offset_y        (req_offset_y),
      .req_offset_z        (req_offset_z),
      .req_cell_index      (req_cell_index),
      .req_particle_weight (req_particle_weight),
      .req_write_value     (req_write_value),
      .req_end_of_batch    (req_end_of_batch),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_node_value      (rsp_node_value),
      .rsp_batch_done      (rsp_batch_done),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Divide by 2^k, rounding half away from zero
   function automatic longint round_shift(input longint x, input int k);
      longint mag;
      longint r;
      mag = (x < 0) ? -x : x;
      r = (mag + (longint'(1) <<< (k - 1))) >>> k;
      return (x < 0) ? -r : r;
   endfunction

   function automatic logic signed [31:0] clip32(input longint x, inout bit sat);
      if (x > SAT_MAX) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (x < SAT_MIN) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return 32'(x);
   endfunction

   // Applies one request to the charge model and returns its response word
   function automatic response_type apply_to_charge_model(input request_type r);
      response_type       rsp;
      longint             d [3];
      longint             f_lo [3];
      longint             f_hi [3];
      longint             w [8];
      longint             base;
      logic signed [31:0] wk;
      bit                 sat;
      int                 n;
      int                 node;
      int                 far_node;
      rsp.status = ST_OK;
      rsp.node_value = '0;
      rsp.batch_done = r.eob;
      sat = 1'b0;
      case (r.func)
         FN_DEPOSIT: begin
            far_node = int'(r.cell_index) + int'(stride_y_cfg) + int'(stride_z_cfg) + 1;
            if (far_node >= GRID_NODES) begin
               rsp.status = ST_RANGE;
            end else begin
               d[0] = longint'(r.offset_x);
               d[1] = longint'(r.offset_y);
               d[2] = longint'(r.offset_z);
               for (int s = 0; s < 3; s++) begin
                  f_lo[s] = 16384 - d[s];
                  f_hi[s] = 16384 + d[s];
               end
               w[0] = round_shift(longint'(r.weight) * longint'(scale_cfg), 16);
               // Split along x, then y, then z; bit s of the corner picks the + side
               for (int s = 0; s < 3; s++) begin
                  n = 1 << s;
                  for (int k = n - 1; k >= 0; k--) begin
                     base = w[k];
                     w[k]     = round_shift(base * f_lo[s], 14);
                     w[k + n] = round_shift(base * f_hi[s], 14);
                  end
               end
               // Corner adds in order, so coincident nodes accumulate in sequence
               for (int k = 0; k < 8; k++) begin
                  node = int'(r.cell_index) + (k & 1)
                       + (((k & 2) != 0) ? int'(stride_y_cfg) : 0)
                       + (((k & 4) != 0) ? int'(stride_z_cfg) : 0);
                  wk = clip32(w[k], sat);
                  charge_model[node] =
                     clip32(longint'(charge_model[node]) + longint'(wk), sat);
               end
               if (sat) rsp.status = ST_SAT;
            end
         end
         FN_READ: rsp.node_value = charge_model[r.cell_index];
         FN_WRITE: charge_model[r.cell_index] = r.write_value;
         default: ;
      endcase
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Response checking and receiver stalls
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_responses
      response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: response word with nothing outstanding, status %h value %h",
                        $time, rsp_status, rsp_node_value);
         end else begin
            want = expected_responses.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("node_value", want.node_value, rsp_node_value);
            check_field("batch_done", 32'(want.batch_done), 32'(rsp_batch_done));
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // ---------------------------------------------------------------------
   // Request and register drivers
   // ---------------------------------------------------------------------

   task automatic release_request();
      if (req_live) begin
         req_valid <= 1'b0;
         req_live = 1'b0;
      end
   endtask

   // Sends one request word; valid stays up so the next word can follow at once
   task automatic send_request(input request_type r);
      if ($urandom_range(0, 99) < idle_pct) begin
         release_request();
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end else if (!req_live) begin
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= r.func;
      req_offset_x        <= r.offset_x;
      req_offset_y        <= r.offset_y;
      req_offset_z        <= r.offset_z;
      req_cell_index      <= r.cell_index;
      req_particle_weight <= r.weight;
      req_write_value     <= r.write_value;
      req_end_of_batch    <= r.eob;
      req_live = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_responses.push_back(apply_to_charge_model(r));
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (expected_responses.size() != 0);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_CHARGE_SCALE: scale_cfg = data;
         CSR_STRIDE_Y:     stride_y_cfg = data[11:0];
         CSR_STRIDE_Z:     stride_z_cfg = data[11:0];
         default: ;
      endcase
   endtask

   // Registers change only with the block idle
   task automatic set_config(input logic [31:0] scale, input int sy, input int sz);
      release_request();
      wait_drained();
      write_csr(CSR_CHARGE_SCALE, scale);
      write_csr(CSR_STRIDE_Y, 32'(sy));
      write_csr(CSR_STRIDE_Z, 32'(sz));
   endtask

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------

   function automatic request_type make_request(input logic [1:0] func,
         input int cell_index, input logic [23:0] weight, input int ox, input int oy,
         input int oz, input logic [31:0] wval, input bit eob);
      request_type r;
      r.func = func;
      r.cell_index = 12'(cell_index);
      r.weight = weight;
      r.offset_x = 16'(ox);
      r.offset_y = 16'(oy);
      r.offset_z = 16'(oz);
      r.write_value = wval;
      r.eob = eob;
      return r;
   endfunction

   // Mostly within [-1, 1], now and then any 16-bit value
   function automatic logic signed [15:0] random_offset();
      int v;
      if ($urandom_range(0, 15) == 0) return 16'($urandom());
      v = int'($urandom_range(0, 32768)) - 16384;
      return 16'(v);
   endfunction

   function automatic logic [31:0] random_small_scale();
      int v;
      v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      return 32'(v);
   endfunction

   // A corner of the last deposit, or any node
   function automatic int random_node();
      int k;
      int node;
      k = $urandom_range(0, 7);
      node = recent_base + (k & 1)
           + (((k & 2) != 0) ? int'(stride_y_cfg) : 0)
           + (((k & 4) != 0) ? int'(stride_z_cfg) : 0);
      if (node >= GRID_NODES || $urandom_range(0, 3) == 0)
         node = $urandom_range(0, GRID_NODES - 1);
      return node;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int roll;
      int top;
      roll = $urandom_range(0, 99);
      r.func = FN_DEPOSIT;
      r.offset_x = random_offset();
      r.offset_y = random_offset();
      r.offset_z = random_offset();
      r.weight = 24'($urandom());
      r.write_value = $urandom();
      r.eob = ($urandom_range(0, 7) == 0);
      // highest base whose farthest corner is still in the store
      top = GRID_NODES - 2 - int'(stride_y_cfg) - int'(stride_z_cfg);
      r.cell_index = (top >= 0) ? 12'($urandom_range(0, top)) : 12'($urandom());
      if (roll < 55) begin
         // pile some deposits onto the same base node to build up charge
         if ($urandom_range(0, 3) == 0 && recent_base <= top)
            r.cell_index = 12'(recent_base);
         recent_base = r.cell_index;
      end else if (roll < 75) begin
         r.func = FN_READ;
         r.cell_index = 12'(random_node());
      end else if (roll < 92) begin
         r.func = FN_WRITE;
         r.cell_index = 12'(random_node());
         if ($urandom_range(0, 3) == 0)
            r.write_value = {r.write_value[31], {15{~r.write_value[31]}}, 16'($urandom())};
      end else begin
         // deposit anywhere, often past the end of the store
         r.cell_index = 12'($urandom());
      end
      return r;
   endfunction

   task automatic run_phase(input logic [31:0] scale, input int sy, input int sz,
                            input int count, input bit hold_midway);
      set_config(scale, sy, sz);
      for (int i = 0; i < count; i++) begin
         if (hold_midway && i == count / 2) begin
            release_request();
            wait_drained();
         end
         send_request(random_request());
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Cleared store and register reset values, range edge at default strides
   task automatic test_reset_state();
      send_request(make_request(FN_READ, GRID_NODES - 1, 24'hFFFFFF, -16384, 16384, 0,
                                32'hFFFF_FFFF, 1'b1));
      send_request(make_request(FN_DEPOSIT, 3822, 24'hFFFFFF, 0, 0, 0, '0, 1'b1));
      send_request(make_request(FN_DEPOSIT, 3823, 24'h010000, 0, 0, 0, '0, 1'b0));
   endtask

   task automatic test_directed_cases();
      set_config(32'h0001_0000, 16, 256);
      // unit charge at offset zero: every corner gets the full weight
      send_request(make_request(FN_DEPOSIT, 0, 24'h010000, 0, 0, 0, '0, 1'b0));
      send_request(make_request(FN_READ, 0, '0, 0, 0, 0, '0, 1'b0));
      send_request(make_request(FN_READ, 273, '0, 0, 0, 0, '0, 1'b0));
      // offsets at the cell faces put all charge on one corner
      send_request(make_request(FN_DEPOSIT, 100, 24'h010000, 16384, -16384, 16384, '0, 1'b1));
      // offsets beyond the cell give negative and oversized factors
      send_request(make_request(FN_DEPOSIT, 100, 24'h008000, -32768, 32767, -32768, '0, 1'b0));
      send_request(make_request(FN_READ, 100, '0, 0, 0, 0, '0, 1'b0));
      send_request(make_request(FN_READ, 357, '0, 0, 0, 0, '0, 1'b0));
      send_request(make_request(FN_WRITE, GRID_NODES - 1, '0, 0, 0, 0, 32'h7FFF_FFFF, 1'b0));
      send_request(make_request(FN_READ, GRID_NODES - 1, '0, 0, 0, 0, '0, 1'b0));
      // node sum clips at the positive limit
      send_request(make_request(FN_WRITE, 200, '0, 0, 0, 0, 32'h7FFF_0000, 1'b0));
      send_request(make_request(FN_DEPOSIT, 200, 24'h010000, 0, 0, 0, '0, 1'b0));
      send_request(make_request(FN_READ, 200, '0, 0, 0, 0, '0, 1'b0));
      send_request(make_request(FN_WRITE, 300, '0, 0, 0, 0, 32'h8000_0000, 1'b0));
      // corner weights clip at both limits
      set_config(32'h7FFF_FFFF, 16, 256);
      send_request(make_request(FN_DEPOSIT, 300, 24'hFFFFFF, 0, 0, 0, '0, 1'b0));
      set_config(32'h8000_0000, 16, 256);
      send_request(make_request(FN_DEPOSIT, 300, 24'hFFFFFF, 16384, 16384, 16384, '0, 1'b0));
      send_request(make_request(FN_READ, 300, '0, 0, 0, 0, '0, 1'b0));
      // unused function code does nothing
      send_request(make_request(FN_UNUSED, GRID_NODES - 1, 24'hFFFFFF, -1, -1, -1,
                                32'hFFFF_FFFF, 1'b1));
      // unit strides: several corners land on the same node
      set_config(32'h0001_0000, 1, 1);
      send_request(make_request(FN_DEPOSIT, 500, 24'h018000, 8192, -8192, 4096, '0, 1'b0));
      send_request(make_request(FN_DEPOSIT, 500, 24'h000000, 100, 200, 300, '0, 1'b0));
      send_request(make_request(FN_READ, 500, '0, 0, 0, 0, '0, 1'b0));
      send_request(make_request(FN_READ, 501, '0, 0, 0, 0, '0, 1'b0));
      send_request(make_request(FN_READ, 502, '0, 0, 0, 0, '0, 1'b1));
   endtask

   // Full rate on both sides, no idle cycles at all
   task automatic test_back_to_back();
      release_request();
      wait_drained();
      idle_pct = 0;
      run_phase(32'h0000_4000, 16, 256, 120, 1'b0);
      release_request();
      wait_drained();
      idle_pct = 37;
   endtask

   task automatic test_random_phases();
      run_phase(32'h0001_0000, 16, 256, 140, 1'b1);
      run_phase(random_small_scale(), 1, 1, 140, 1'b0);
      // extreme strides: every deposit is dropped
      run_phase(32'h7FFF_FFFF, 4095, 4095, 40, 1'b0);
      run_phase(32'h8000_0000, 7, 100, 110, 1'b0);
      run_phase($urandom(), $urandom_range(1, 64), $urandom_range(1, 1024), 140, 1'b0);
      run_phase(random_small_scale(), 64, 1024, 140, 1'b0);
      run_phase(random_small_scale(), 1000, 2000, 100, 1'b0);
   endtask

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("trilinear_charge_deposit test failed");
      $finish;
   end

   initial begin
      foreach (charge_model[i]) charge_model[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_cases();
      test_back_to_back();
      test_random_phases();
      release_request();
      wait_drained();
      // catch any stray word after the last
      repeat (64) @(posedge clock);
      if (error_count == 0)
         $display("trilinear_charge_deposit test passed");
      else
         $display("trilinear_charge_deposit test failed");
      $finish;
   end

endmodule
